>>> rtl/core/mm_pkg.sv
// Shared constants for the matrix multiply block: dimensions, widths,
// function codes and configuration register indexes. No dependencies.
`default_nettype none

package mm_pkg;

    localparam int MAX_DIM   = 8;
    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int DIM_W     = 4;
    localparam int ELEM_W    = 16;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int ACC_W     = 35;
    localparam int FUNC_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = DIM_W;

    localparam logic [FUNC_W-1:0] FUNC_WR_A    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WR_B    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

    typedef logic [ELEM_W-1:0] t_elem;
    typedef logic [ADDR_W-1:0] t_addr;

endpackage

`default_nettype wire

>>> rtl/core/mm_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module mm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/core/matrix_multiply.sv
// Top level of the matrix multiply block: element stores, MAC sequencer,
// output register and configuration registers. Depends on mm_pkg, mm_ram.
//
//  channel   valid     stall     payload
//  -------   -------   -------   --------------------------------------------
//  input     i_valid   o_stall   i_func, i_row_index, i_col_index, i_element
//  output    o_valid   i_stall   o_out_row, o_out_col, o_product_value, o_last
//  config    i_cfg_we  (none)    i_cfg_index, i_cfg_data
//
// A write item goes straight into its element store.
// A compute item yields rows_a * cols_b results and can be held by output
// stalls: each result runs inner_dim reads of both stores through one
// registered multiplier and accumulator, then drains the pipeline.
// Synchronous active-low reset; the stores are not cleared.
// o_stall is high for the whole compute item.
`default_nettype none

module matrix_multiply
    import mm_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [FUNC_W-1:0]       i_func,
    input  wire logic [2:0]              i_row_index,
    input  wire logic [2:0]              i_col_index,
    input  wire logic signed [ELEM_W-1:0] i_element,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [2:0]                   o_out_row,
    output logic [2:0]                   o_out_col,
    output logic signed [ACC_W-1:0]      o_product_value,
    output logic                         o_last,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_W-1:0]        i_cfg_data
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] d;
        d = v[DIM_W-1:0];
        if (d == '0) begin
            return DIM_W'(1);
        end else if (d > DIM_MAX) begin
            return DIM_MAX;
        end
        return d;
    endfunction

    logic [1:0]       r_state;
    logic [DIM_W-1:0] r_rows_a, r_inner, r_cols_b;
    logic [IDX_W-1:0] r_row, r_col, r_k;

    logic             r_p1, r_p1_first, r_p1_last;
    logic             r_p2, r_p2_first, r_p2_last;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic             r_done;

    logic             in_acc;
    logic             wr_ok;
    logic             a_we, b_we;
    t_addr            waddr, a_raddr, b_raddr;
    t_elem            a_rdata, b_rdata;
    logic             k_last, col_last, row_last;
    logic             load_out;

    assign o_stall = (r_state != S_IDLE);
    assign in_acc  = i_valid && !o_stall;
    assign wr_ok   = ({1'b0, i_row_index} < (IDX_W + 1)'(MAX_DIM)) &&
                     ({1'b0, i_col_index} < (IDX_W + 1)'(MAX_DIM));
    assign a_we    = in_acc && (i_func == FUNC_WR_A) && wr_ok;
    assign b_we    = in_acc && (i_func == FUNC_WR_B) && wr_ok;
    assign waddr   = {i_row_index[IDX_W-1:0], i_col_index[IDX_W-1:0]};
    assign a_raddr = {r_row, r_k};
    assign b_raddr = {r_k, r_col};

    assign k_last   = ({1'b0, r_k}   == (r_inner  - DIM_W'(1)));
    assign col_last = ({1'b0, r_col} == (r_cols_b - DIM_W'(1)));
    assign row_last = ({1'b0, r_row} == (r_rows_a - DIM_W'(1)));
    assign load_out = (r_state == S_WAIT) && r_done && (!o_valid || !i_stall);

    mm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_a_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (waddr),
        .i_wdata (i_element),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    mm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_b_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (waddr),
        .i_wdata (i_element),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    // configuration, saturated on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a <= DIM_MAX;
            r_inner  <= DIM_MAX;
            r_cols_b <= DIM_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROWS_A:    r_rows_a <= clamp_dim(i_cfg_data);
                CFG_INNER_DIM: r_inner  <= clamp_dim(i_cfg_data);
                CFG_COLS_B:    r_cols_b <= clamp_dim(i_cfg_data);
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_k     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_func == FUNC_COMPUTE)) begin
                        r_row   <= '0;
                        r_col   <= '0;
                        r_k     <= '0;
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    if (k_last) begin
                        r_k     <= '0;
                        r_state <= S_WAIT;
                    end else begin
                        r_k <= r_k + IDX_W'(1);
                    end
                end
                S_WAIT: begin
                    if (load_out) begin
                        if (col_last) begin
                            r_col <= '0;
                            if (row_last) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_row   <= r_row + IDX_W'(1);
                                r_state <= S_ISSUE;
                            end
                        end else begin
                            r_col   <= r_col + IDX_W'(1);
                            r_state <= S_ISSUE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // read, multiply, accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1   <= 1'b0;
            r_p2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_p1 <= (r_state == S_ISSUE);
            r_p2 <= r_p1;
            if (r_p2 && r_p2_last) begin
                r_done <= 1'b1;
            end else if (load_out) begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_first <= (r_k == '0);
        r_p1_last  <= k_last;
        r_p2_first <= r_p1_first;
        r_p2_last  <= r_p1_last;
        r_prod     <= $signed(a_rdata) * $signed(b_rdata);
        if (r_p2) begin
            r_acc <= (r_p2_first ? ACC_W'(0) : r_acc) +
                     {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (load_out) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_out_row       <= 3'(r_row);
            o_out_col       <= 3'(r_col);
            o_product_value <= r_acc;
            o_last          <= col_last && row_last;
        end
    end

    a_pipe_in_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p1 || r_p2) |-> (r_state != S_IDLE))
        else $error("MAC pipeline active outside a compute item");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_WAIT))
        else $error("finished sum outside the wait state");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && col_last && row_last) |=> (r_state == S_IDLE && o_last))
        else $error("final result did not end the compute item");

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_we || b_we) |-> (r_state == S_IDLE))
        else $error("store written during a compute item");

endmodule

`default_nettype wire

>>> test/matrix_multiply_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for matrix_multiply: loads A and B through element writes,
// predicts every product element in a scoreboard class and checks each result.
// Depends on mm_pkg and the matrix_multiply RTL.

typedef struct {
    logic [2:0]               row;
    logic [2:0]               col;
    logic [mm_pkg::ACC_W-1:0] value;
    logic                     last;
} t_mm_product;

class matmul_scoreboard;
    logic [mm_pkg::ELEM_W-1:0] a_mem [mm_pkg::DEPTH];
    logic [mm_pkg::ELEM_W-1:0] b_mem [mm_pkg::DEPTH];
    int unsigned rows;
    int unsigned inner;
    int unsigned cols;
    t_mm_product due_products [$];
    int errors;

    function new();
        rows   = mm_pkg::MAX_DIM;
        inner  = mm_pkg::MAX_DIM;
        cols   = mm_pkg::MAX_DIM;
        errors = 0;
    endfunction

    function void set_dim(logic [mm_pkg::CFG_IDX_W-1:0] idx, logic [mm_pkg::CFG_W-1:0] raw);
        int unsigned dim;
        dim = (raw == 0) ? 1 : ((raw > mm_pkg::MAX_DIM) ? mm_pkg::MAX_DIM : raw);
        case (idx)
            mm_pkg::CFG_ROWS_A:    rows  = dim;
            mm_pkg::CFG_INNER_DIM: inner = dim;
            mm_pkg::CFG_COLS_B:    cols  = dim;
            default: ;
        endcase
    endfunction

    function void note_item(logic [mm_pkg::FUNC_W-1:0] func, logic [2:0] row,
                            logic [2:0] col, logic [mm_pkg::ELEM_W-1:0] elem);
        t_mm_product res;
        longint acc;
        case (func)
            mm_pkg::FUNC_WR_A: a_mem[{row, col}] = elem;
            mm_pkg::FUNC_WR_B: b_mem[{row, col}] = elem;
            mm_pkg::FUNC_COMPUTE: begin
                for (int r = 0; r < rows; r++) begin
                    for (int c = 0; c < cols; c++) begin
                        acc = 0;
                        for (int k = 0; k < inner; k++)
                            acc += longint'($signed(a_mem[r * mm_pkg::MAX_DIM + k])) *
                                   longint'($signed(b_mem[k * mm_pkg::MAX_DIM + c]));
                        res.row   = 3'(r);
                        res.col   = 3'(c);
                        res.value = acc[mm_pkg::ACC_W-1:0];
                        res.last  = (r == rows - 1) && (c == cols - 1);
                        due_products.push_back(res);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function void field_check(string name, logic signed [63:0] want, logic signed [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_product(logic [2:0] row, logic [2:0] col,
                                logic [mm_pkg::ACC_W-1:0] value, logic last);
        t_mm_product want;
        if (due_products.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual row %0d col %0d value %0d",
                     $time, row, col, $signed(value));
            errors++;
            return;
        end
        want = due_products.pop_front();
        field_check("out_row", want.row, row);
        field_check("out_col", want.col, col);
        field_check("product_value", $signed(want.value), $signed(value));
        field_check("last", want.last, last);
    endfunction
endclass

module matrix_multiply_tb;
    import mm_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_RESERVED = 2'd3;
    localparam int N_ITEMS       = 220;
    localparam int PHASE_ITEMS   = 28;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 12;
    localparam int LIMIT_CYCLES  = 2000000;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic [FUNC_W-1:0]     i_func      = '0;
    logic [2:0]            i_row_index = '0;
    logic [2:0]            i_col_index = '0;
    logic [ELEM_W-1:0]     i_element   = '0;
    logic                  i_stall     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]      i_cfg_data  = '0;
    logic                  o_stall;
    logic                  o_valid;
    logic [2:0]            o_out_row;
    logic [2:0]            o_out_col;
    logic [ACC_W-1:0]      o_product_value;
    logic                  o_last;

    matmul_scoreboard sb = new();
    bit a_done [DEPTH];
    bit b_done [DEPTH];
    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_start    = 1'b0;
    bit hold_taken    = 1'b0;
    int hold_left     = 0;
    int items_sent    = 0;
    int cycle_cnt     = 0;

    matrix_multiply uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_func          (i_func),
        .i_row_index     (i_row_index),
        .i_col_index     (i_col_index),
        .i_element       (i_element),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_product_value (o_product_value),
        .o_last          (o_last),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_product(o_out_row, o_out_col, o_product_value, o_last);
        if (hold_start && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99, 0) < stall_pct);
        end
    end

    function automatic logic [ELEM_W-1:0] rand_elem();
        case ($urandom_range(7, 0))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(logic [FUNC_W-1:0] f, logic [2:0] r, logic [2:0] c,
                             logic [ELEM_W-1:0] e);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_func      <= f;
        i_row_index <= r;
        i_col_index <= c;
        i_element   <= e;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        sb.note_item(f, r, c, e);
        if (f != FUNC_RESERVED)
            items_sent++;
    endtask

    task automatic put_elem(logic [FUNC_W-1:0] f, logic [2:0] r, logic [2:0] c,
                            logic [ELEM_W-1:0] e);
        send_item(f, r, c, e);
        if (f == FUNC_WR_A)
            a_done[{r, c}] = 1'b1;
        else
            b_done[{r, c}] = 1'b1;
    endtask

    // fill any operand entry the product will read before issuing it
    task automatic issue_product();
        for (int r = 0; r < sb.rows; r++)
            for (int k = 0; k < sb.inner; k++)
                if (!a_done[r * MAX_DIM + k])
                    put_elem(FUNC_WR_A, 3'(r), 3'(k), rand_elem());
        for (int k = 0; k < sb.inner; k++)
            for (int c = 0; c < sb.cols; c++)
                if (!b_done[k * MAX_DIM + c])
                    put_elem(FUNC_WR_B, 3'(k), 3'(c), rand_elem());
        send_item(FUNC_COMPUTE, 3'($urandom), 3'($urandom), 16'($urandom));
    endtask

    task automatic mixed_items(input int n);
        int unsigned pick;
        int unsigned lim_r;
        int unsigned lim_c;
        logic [FUNC_W-1:0] f;
        repeat (n) begin
            pick = $urandom_range(99, 0);
            if (pick < 9) begin
                issue_product();
            end else if (pick < 13) begin
                send_item(FUNC_RESERVED, 3'($urandom), 3'($urandom), 16'($urandom));
            end else begin
                f     = ($urandom_range(1, 0) == 0) ? FUNC_WR_A : FUNC_WR_B;
                lim_r = (f == FUNC_WR_A) ? sb.rows : sb.inner;
                lim_c = (f == FUNC_WR_A) ? sb.inner : sb.cols;
                if ($urandom_range(3, 0) == 0) begin
                    lim_r = MAX_DIM;
                    lim_c = MAX_DIM;
                end
                put_elem(f, 3'($urandom_range(lim_r - 1, 0)), 3'($urandom_range(lim_c - 1, 0)),
                         rand_elem());
            end
        end
    endtask

    task automatic drain_products();
        i_valid <= 1'b0;
        while (sb.due_products.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_dims(logic [CFG_W-1:0] r, logic [CFG_W-1:0] k, logic [CFG_W-1:0] c);
        drain_products();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ROWS_A;
        i_cfg_data  <= r;
        @(posedge i_clk);
        sb.set_dim(CFG_ROWS_A, r);
        i_cfg_index <= CFG_INNER_DIM;
        i_cfg_data  <= k;
        @(posedge i_clk);
        sb.set_dim(CFG_INNER_DIM, k);
        i_cfg_index <= CFG_COLS_B;
        i_cfg_data  <= c;
        @(posedge i_clk);
        sb.set_dim(CFG_COLS_B, c);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int unsigned ph;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero dimensions saturate to one
        write_dims(4'd0, 4'd0, 4'd0);
        put_elem(FUNC_WR_A, 3'd0, 3'd0, 16'h7fff);
        put_elem(FUNC_WR_B, 3'd0, 3'd0, 16'h8000);
        send_item(FUNC_COMPUTE, 3'd0, 3'd0, 16'h0000);
        send_item(FUNC_RESERVED, 3'd7, 3'd7, 16'hffff);
        put_elem(FUNC_WR_A, 3'd7, 3'd7, 16'h0100);
        put_elem(FUNC_WR_B, 3'd7, 3'd7, 16'h8000);
        send_item(FUNC_COMPUTE, 3'd7, 3'd7, 16'hffff);

        // largest positive sum over a full inner dimension
        write_dims(4'd1, 4'd15, 4'd1);
        for (int k = 0; k < MAX_DIM; k++) begin
            put_elem(FUNC_WR_A, 3'd0, 3'(k), 16'h8000);
            put_elem(FUNC_WR_B, 3'(k), 3'd0, 16'h8000);
        end
        send_item(FUNC_COMPUTE, 3'd0, 3'd0, 16'h0000);

        items_sent = 0;
        ph = 0;
        while (items_sent < N_ITEMS) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 65; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 65; end
                default: begin send_idle_pct = 30; stall_pct = 30; end
            endcase
            case (ph)
                0: write_dims(4'd8, 4'd8, 4'd8);
                1: write_dims(4'd0, 4'd9, 4'd15);
                default: write_dims(4'($urandom_range(15, 0)), 4'($urandom_range(15, 0)),
                                    4'($urandom_range(15, 0)));
            endcase
            if (ph == 2) begin
                hold_start = 1'b1;
                issue_product();
            end
            if (ph == 3) begin
                mixed_items(PHASE_ITEMS / 2);
                issue_product();
                drain_products();
                mixed_items(PHASE_ITEMS / 2);
            end else begin
                mixed_items(PHASE_ITEMS);
            end
            issue_product();
            ph++;
        end

        drain_products();
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
